FILE: src/vfr_timecode_to_cfr_remap_defines.svh
// Assertion helpers shared by the remapper RTL.
// Both macros expect clk and arst_n in the scope where they are used.
`ifndef VFR_TIMECODE_TO_CFR_REMAP_DEFINES_SVH
`define VFR_TIMECODE_TO_CFR_REMAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VFR2CFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VFR2CFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vfr2cfr_pkg.sv
`default_nettype none

package vfr2cfr_pkg;

	// Field and register widths.
	localparam int TC_W       = 40;
	localparam int FL_W       = 24;
	localparam int THR_W      = 10;
	localparam int TIME_W     = 48;
	localparam int OIDX_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Default parameter values.
	localparam int DEF_MAX_RUN    = 31;
	localparam int DEF_INDEX_BITS = 24;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_THR_FIRST  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_THR_MORE   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_EXTEND     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_REBASE     = CFG_IDX_W'(4);

	// Register reset values.
	localparam logic [FL_W-1:0]  RST_FRAME_LEN = FL_W'(40960);
	localparam logic [THR_W-1:0] RST_THR_FIRST = THR_W'(102);
	localparam logic [THR_W-1:0] RST_THR_MORE  = THR_W'(230);
	localparam logic             RST_EXTEND    = 1'b1;
	localparam logic             RST_REBASE    = 1'b0;

	// Commands from the controller to the datapath, one per step.
	typedef struct packed {
		logic load;
		logic prep;
		logic diff;
		logic first;
		logic more;
		logic err;
		logic acc;
		logic dsub;
		logic dinit;
		logic dstep;
		logic dfin;
		logic emit;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic more_hit;
		logic run_full;
		logic ext_go;
		logic div_last;
		logic pending;
		logic last_next;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: src/vfr_timecode_to_cfr_remap.sv
// Sequential remapper: a new timecode word is taken only when the sequencer is idle, after the last one is done.
// A word with one copy steps through load, prep, diff, first, more, err and acc before its result is loaded;
// each further copy of the run repeats the more step, and each further result word takes another emit.
// An end-of-stream word with extension adds the dsub, dinit, dstep and dfin steps of the rounding divider.
// The output register holds the last word, so the next input is taken while it waits.
// Asynchronous active-low reset restores register defaults and clears all stream state.
`default_nettype none

module vfr_timecode_to_cfr_remap #(
	parameter int MAX_RUN    = vfr2cfr_pkg::DEF_MAX_RUN,
	parameter int INDEX_BITS = vfr2cfr_pkg::DEF_INDEX_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vfr2cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vfr2cfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [vfr2cfr_pkg::TC_W-1:0]        timecode,
	input  logic                                end_of_stream,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic                                blank,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      source_frame,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      output_frame,
	output logic                                is_last,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      dup_count,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      drop_count,
	output logic [vfr2cfr_pkg::TIME_W-1:0]      error_sum,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      item_count,
	output logic                                overflow
);
	import vfr2cfr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	// Register writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	vfr2cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vfr2cfr_dp #(
		.MAX_RUN    (MAX_RUN),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.timecode      (timecode),
		.end_of_stream (end_of_stream),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.blank         (blank),
		.source_frame  (source_frame),
		.output_frame  (output_frame),
		.is_last       (is_last),
		.dup_count     (dup_count),
		.drop_count    (drop_count),
		.error_sum     (error_sum),
		.item_count    (item_count),
		.overflow      (overflow)
	);

endmodule

`default_nettype wire

FILE: src/vfr2cfr_ctrl.sv
`default_nettype none

module vfr2cfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vfr2cfr_pkg::sts_t  sts,
	output vfr2cfr_pkg::cmd_t  cmd
);
	import vfr2cfr_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_DIFF  = 4'd2;
	localparam logic [3:0] S_FIRST = 4'd3;
	localparam logic [3:0] S_MORE  = 4'd4;
	localparam logic [3:0] S_ERR   = 4'd5;
	localparam logic [3:0] S_ACC   = 4'd6;
	localparam logic [3:0] S_DSUB  = 4'd7;
	localparam logic [3:0] S_DINIT = 4'd8;
	localparam logic [3:0] S_DSTEP = 4'd9;
	localparam logic [3:0] S_DFIN  = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	// A new word is taken only when the sequencer is idle.
	assign in_stall = (state_q != S_IDLE);

	// Next state and step commands.
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_nx = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = S_FIRST;
			end
			S_FIRST: begin
				cmd.first = 1'b1;
				state_nx  = S_MORE;
			end
			S_MORE: begin
				cmd.more = 1'b1;
				if (!sts.more_hit || sts.run_full) begin
					state_nx = S_ERR;
				end
			end
			S_ERR: begin
				cmd.err  = 1'b1;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc  = 1'b1;
				state_nx = sts.ext_go ? S_DSUB : S_EMIT;
			end
			S_DSUB: begin
				cmd.dsub = 1'b1;
				state_nx = S_DINIT;
			end
			S_DINIT: begin
				cmd.dinit = 1'b1;
				state_nx  = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.dstep = 1'b1;
				if (sts.div_last) begin
					state_nx = S_DFIN;
				end
			end
			S_DFIN: begin
				cmd.dfin = 1'b1;
				state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.pending) begin
					state_nx = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_next) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

FILE: src/vfr2cfr_dp.sv
`default_nettype none

module vfr2cfr_dp #(
	parameter int MAX_RUN    = vfr2cfr_pkg::DEF_MAX_RUN,
	parameter int INDEX_BITS = vfr2cfr_pkg::DEF_INDEX_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [vfr2cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vfr2cfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [vfr2cfr_pkg::TC_W-1:0]        timecode,
	input  logic                                end_of_stream,
	input  vfr2cfr_pkg::cmd_t                   cmd,
	output vfr2cfr_pkg::sts_t                   sts,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                kind,
	output logic                                blank,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      source_frame,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      output_frame,
	output logic                                is_last,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      dup_count,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      drop_count,
	output logic [vfr2cfr_pkg::TIME_W-1:0]      error_sum,
	output logic [vfr2cfr_pkg::OIDX_W-1:0]      item_count,
	output logic                                overflow
);
	import vfr2cfr_pkg::*;

	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int QW    = RUN_W + 1;
	localparam int SW    = $clog2(QW);
	localparam int DVW   = FL_W + 1 + RUN_W;
	localparam int REM_W = TC_W + 2;
	localparam int DW    = TIME_W + 2;
	localparam int PW    = DW + 8;
	localparam int AW    = THR_W + FL_W;
	localparam int IB    = INDEX_BITS;
	localparam logic [RUN_W-1:0] RUN_LIM = RUN_W'(MAX_RUN);

	// Configuration registers.
	logic [FL_W-1:0]  fl_cfg_q;
	logic [THR_W-1:0] thr1_q;
	logic [THR_W-1:0] thr2_q;
	logic             ext_en_q;
	logic             rebase_q;

	// Stream state.
	logic [TIME_W-1:0] cfr_q;
	logic [IB-1:0]     ocnt_q;
	logic [IB-1:0]     icnt_q;
	logic [TC_W-1:0]   prev_q;
	logic [TC_W-1:0]   first_q;
	logic [IB-1:0]     dups_q;
	logic [IB-1:0]     drops_q;
	logic [TIME_W-1:0] errtot_q;
	logic              ovf_q;
	logic [RUN_W-1:0]  run_q;
	logic [RUN_W-1:0]  ext_q;

	// Per-word working registers.
	logic [TC_W-1:0]       t_q;
	logic                  eos_q;
	logic                  has_prev_q;
	logic [IB-1:0]         cur_q;
	logic [FL_W-1:0]       fl_q;
	logic [AW-1:0]         a1_q;
	logic [AW-1:0]         a2_q;
	logic signed [DW-1:0]  diff_q;
	logic [TIME_W-1:0]     abs_q;
	logic                  dpos_q;
	logic [TC_W-1:0]       d_q;
	logic [REM_W-1:0]      rem_q;
	logic [DVW-1:0]        dv_q;
	logic [QW-1:0]         quo_q;
	logic [SW-1:0]         step_q;

	// Output register.
	logic              ov_q;
	logic              kind_q;
	logic              blank_q;
	logic [OIDX_W-1:0] src_q;
	logic [OIDX_W-1:0] ofr_q;
	logic              last_q;
	logic [OIDX_W-1:0] dup_o_q;
	logic [OIDX_W-1:0] drop_o_q;
	logic [TIME_W-1:0] err_o_q;
	logic [OIDX_W-1:0] cnt_o_q;
	logic              ovf_o_q;

	// Gap threshold tests: gap * 256 against threshold * frame length.
	logic gt1;
	logic gt2;
	assign gt1 = $signed({diff_q, 8'd0}) > $signed(PW'(a1_q));
	assign gt2 = $signed({diff_q, 8'd0}) > $signed(PW'(a2_q));

	logic run_full;
	assign run_full = (run_q >= RUN_LIM);

	// Saturating advance of the output frame start.
	logic [TIME_W:0]   cfr_sum;
	logic [TIME_W-1:0] cfr_nx;
	assign cfr_sum = {1'b0, cfr_q} + (TIME_W + 1)'(fl_q);
	assign cfr_nx  = cfr_sum[TIME_W] ? '1 : cfr_sum[TIME_W-1:0];

	// Saturating counter increments.
	logic [IB-1:0] dups_inc;
	logic [IB-1:0] drops_inc;
	logic [IB-1:0] icnt_inc;
	logic [IB-1:0] ocnt_inc;
	assign dups_inc  = (&dups_q)  ? dups_q  : dups_q  + 1'b1;
	assign drops_inc = (&drops_q) ? drops_q : drops_q + 1'b1;
	assign icnt_inc  = (&icnt_q)  ? icnt_q  : icnt_q  + 1'b1;
	assign ocnt_inc  = (&ocnt_q)  ? ocnt_q  : ocnt_q  + 1'b1;

	// Saturating error accumulation.
	logic [TIME_W:0]   err_sum;
	logic [TIME_W-1:0] errtot_nx;
	assign err_sum   = {1'b0, errtot_q} + {1'b0, abs_q};
	assign errtot_nx = err_sum[TIME_W] ? '1 : err_sum[TIME_W-1:0];

	// Absolute timing error against the next output start.
	logic [TIME_W-1:0] t_ext;
	assign t_ext = TIME_W'(t_q);

	// Divider step: compare remainder with the shifted divisor.
	logic div_fit;
	assign div_fit = (REM_W'(dv_q) <= rem_q);

	// Extension copy count, clamped to at least one and at most the run limit.
	logic [RUN_W-1:0] copies;
	logic [RUN_W-1:0] copies_m1;
	logic             copies_ovf;
	always_comb begin
		copies_ovf = 1'b0;
		if (!has_prev_q || !dpos_q || (quo_q == '0)) begin
			copies = RUN_W'(1);
		end else if (quo_q > QW'(MAX_RUN)) begin
			copies     = RUN_LIM;
			copies_ovf = 1'b1;
		end else begin
			copies = quo_q[RUN_W-1:0];
		end
	end
	assign copies_m1 = copies - 1'b1;

	logic [IB:0]   dext_sum;
	logic [IB-1:0] dups_ext;
	assign dext_sum = {1'b0, dups_q} + (IB + 1)'(copies_m1);
	assign dups_ext = dext_sum[IB] ? '1 : dext_sum[IB-1:0];

	// Emission bookkeeping.
	logic            run_nz;
	logic            ext_nz;
	logic [RUN_W:0]  frames_left;
	logic            last_next;
	assign run_nz      = (run_q != '0);
	assign ext_nz      = (ext_q != '0);
	assign frames_left = (RUN_W + 1)'(run_q) + (RUN_W + 1)'(ext_q);
	assign last_next   = eos_q ? (frames_left == '0) : (frames_left == (RUN_W + 1)'(1));

	logic out_free;
	assign out_free = !ov_q || !out_stall;

	assign sts.more_hit  = gt2;
	assign sts.run_full  = run_full;
	assign sts.ext_go    = eos_q && ext_en_q;
	assign sts.div_last  = (step_q == '0);
	assign sts.pending   = run_nz || ext_nz || eos_q;
	assign sts.last_next = last_next;
	assign sts.out_free  = out_free;

	// Configuration, stream state and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_cfg_q <= RST_FRAME_LEN;
			thr1_q   <= RST_THR_FIRST;
			thr2_q   <= RST_THR_MORE;
			ext_en_q <= RST_EXTEND;
			rebase_q <= RST_REBASE;
			cfr_q    <= '0;
			ocnt_q   <= '0;
			icnt_q   <= '0;
			prev_q   <= '0;
			first_q  <= '0;
			dups_q   <= '0;
			drops_q  <= '0;
			errtot_q <= '0;
			ovf_q    <= 1'b0;
			run_q    <= '0;
			ext_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_FRAME_LEN: fl_cfg_q <= cfg_data[FL_W-1:0];
					REG_THR_FIRST: thr1_q   <= cfg_data[THR_W-1:0];
					REG_THR_MORE:  thr2_q   <= cfg_data[THR_W-1:0];
					REG_EXTEND:    ext_en_q <= cfg_data[0];
					REG_REBASE:    rebase_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				run_q <= '0;
				ext_q <= '0;
				if (icnt_q == '0) begin
					first_q <= timecode;
				end
			end
			if (cmd.first && has_prev_q) begin
				if (gt1) begin
					cfr_q <= cfr_nx;
					run_q <= RUN_W'(1);
				end else begin
					drops_q <= drops_inc;
				end
			end
			if (cmd.more && gt2) begin
				if (run_full) begin
					ovf_q <= 1'b1;
				end else begin
					cfr_q <= cfr_nx;
					run_q <= run_q + 1'b1;
					if (has_prev_q) begin
						dups_q <= dups_inc;
					end
				end
			end
			if (cmd.acc) begin
				errtot_q <= errtot_nx;
				icnt_q   <= icnt_inc;
				if (!eos_q) begin
					prev_q <= t_q;
				end
			end
			if (cmd.dfin) begin
				ext_q  <= copies;
				dups_q <= dups_ext;
				if (copies_ovf) begin
					ovf_q <= 1'b1;
				end
			end
			// Output word valid.
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			if (cmd.emit) begin
				if (run_nz) begin
					run_q  <= run_q - 1'b1;
					ocnt_q <= ocnt_inc;
				end else if (ext_nz) begin
					ext_q  <= ext_q - 1'b1;
					ocnt_q <= ocnt_inc;
				end
				// The summary word closes the stream.
				if (last_next && eos_q) begin
					cfr_q    <= '0;
					ocnt_q   <= '0;
					icnt_q   <= '0;
					prev_q   <= '0;
					first_q  <= '0;
					dups_q   <= '0;
					drops_q  <= '0;
					errtot_q <= '0;
					ovf_q    <= 1'b0;
				end
			end
		end
	end

	// Per-word working registers and the output payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q        <= timecode;
			eos_q      <= end_of_stream;
			has_prev_q <= (icnt_q != '0);
			cur_q      <= icnt_q;
			fl_q       <= (fl_cfg_q == '0) ? FL_W'(1) : fl_cfg_q;
		end
		if (cmd.prep) begin
			if (rebase_q) begin
				t_q <= (t_q >= first_q) ? t_q - first_q : '0;
			end
			a1_q <= AW'(thr1_q) * AW'(fl_q);
		end
		if (cmd.diff) begin
			diff_q <= $signed(DW'(t_q)) - $signed(DW'(cfr_q));
			a2_q   <= AW'(thr2_q) * AW'(fl_q);
		end
		if (cmd.first && has_prev_q && gt1) begin
			diff_q <= diff_q - $signed(DW'(fl_q));
		end
		if (cmd.more && gt2 && !run_full) begin
			diff_q <= diff_q - $signed(DW'(fl_q));
		end
		if (cmd.err) begin
			abs_q <= (t_ext >= cfr_q) ? t_ext - cfr_q : cfr_q - t_ext;
		end
		if (cmd.dsub) begin
			dpos_q <= (t_q >= prev_q);
			d_q    <= t_q - prev_q;
		end
		// Rounded quotient (2d + len) / (2 len), one bit per cycle.
		if (cmd.dinit) begin
			rem_q  <= REM_W'({d_q, 1'b0}) + REM_W'(fl_q);
			dv_q   <= {fl_q, 1'b0, {RUN_W{1'b0}}};
			quo_q  <= '0;
			step_q <= SW'(QW - 1);
		end
		if (cmd.dstep) begin
			if (div_fit) begin
				rem_q <= rem_q - REM_W'(dv_q);
			end
			quo_q  <= {quo_q[QW-2:0], div_fit};
			dv_q   <= dv_q >> 1;
			step_q <= step_q - 1'b1;
		end
		if (cmd.emit) begin
			kind_q   <= !run_nz && !ext_nz;
			blank_q  <= run_nz && !has_prev_q;
			if (run_nz) begin
				src_q <= has_prev_q ? OIDX_W'(cur_q - 1'b1) : '0;
			end else if (ext_nz) begin
				src_q <= OIDX_W'(cur_q);
			end else begin
				src_q <= '0;
			end
			ofr_q    <= OIDX_W'(ocnt_q);
			last_q   <= last_next;
			dup_o_q  <= OIDX_W'(dups_q);
			drop_o_q <= OIDX_W'(drops_q);
			err_o_q  <= errtot_q;
			cnt_o_q  <= OIDX_W'(icnt_q);
			ovf_o_q  <= ovf_q;
		end
	end

	assign out_valid    = ov_q;
	assign kind         = kind_q;
	assign blank        = blank_q;
	assign source_frame = src_q;
	assign output_frame = ofr_q;
	assign is_last      = last_q;
	assign dup_count    = dup_o_q;
	assign drop_count   = drop_o_q;
	assign error_sum    = err_o_q;
	assign item_count   = cnt_o_q;
	assign overflow     = ovf_o_q;

	`include "vfr_timecode_to_cfr_remap_defines.svh"

	`VFR2CFR_ASSERT_NOW(a_run_bound, 1'b1, run_q <= RUN_LIM, "copy run above limit")
	`VFR2CFR_ASSERT_NOW(a_ext_bound, 1'b1, ext_q <= RUN_LIM, "extension run above limit")
	`VFR2CFR_ASSERT_NOW(a_emit_room, cmd.emit, out_free, "word loaded into a full output")
	`VFR2CFR_ASSERT_NEXT(a_eos_clear, cmd.emit && last_next && eos_q, (icnt_q == '0) && (cfr_q == '0), "stream state not cleared after summary")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
	import vfr2cfr_pkg::*;

	localparam int      CYCLE_LIMIT   = 3000000;
	localparam int      SETTLE_CYCLES = 120;
	localparam int      LONG_HOLD     = 400;
	localparam int      RUN_LIMIT     = DEF_MAX_RUN;
	localparam longint  TC_MAX        = 64'hFF_FFFF_FFFF;
	localparam longint  TIME_MAX      = 64'hFFFF_FFFF_FFFF;
	localparam longint  INDEX_MAX     = 64'hFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

	// One result word as the block presents it.
	typedef struct packed {
		logic              kind;
		logic              blank;
		logic [OIDX_W-1:0] source_frame;
		logic [OIDX_W-1:0] output_frame;
		logic              is_last;
		logic [OIDX_W-1:0] dup_count;
		logic [OIDX_W-1:0] drop_count;
		logic [TIME_W-1:0] error_sum;
		logic [OIDX_W-1:0] item_count;
		logic              overflow;
	} cfr_word_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

	// Directed row: a timecode word or a register write, with optional typed results.
	typedef struct {
		row_op_t              op;
		logic [CFG_IDX_W-1:0] reg_idx;
		longint               value;
		logic                 eos;
		int                   exp_n;
		int                   exp_ovf;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [TC_W-1:0]       timecode = '0;
	logic                  end_of_stream = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  kind;
	logic                  blank;
	logic [OIDX_W-1:0]     source_frame;
	logic [OIDX_W-1:0]     output_frame;
	logic                  is_last;
	logic [OIDX_W-1:0]     dup_count;
	logic [OIDX_W-1:0]     drop_count;
	logic [TIME_W-1:0]     error_sum;
	logic [OIDX_W-1:0]     item_count;
	logic                  overflow;

	// Register copies kept by the predictor.
	logic [FL_W-1:0]  cf_frame_len = RST_FRAME_LEN;
	logic [THR_W-1:0] cf_thr_first = RST_THR_FIRST;
	logic [THR_W-1:0] cf_thr_more  = RST_THR_MORE;
	logic             cf_extend    = RST_EXTEND;
	logic             cf_rebase    = RST_REBASE;

	// Stream state kept by the predictor.
	longint            next_out_time = 0;
	logic [OIDX_W-1:0] out_count = '0;
	logic [OIDX_W-1:0] in_count = '0;
	longint            prev_tc = 0;
	longint            first_tc = 0;
	logic [OIDX_W-1:0] dup_total = '0;
	logic [OIDX_W-1:0] drop_total = '0;
	longint            err_total = 0;
	logic              run_cut = 1'b0;

	cfr_word_t cfr_frames_due[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	logic      calm = 1'b0;
	logic      hold_req = 1'b0;
	logic      hold_done = 1'b0;

	stim_row_t directed_rows [0:26] = '{
		'{ROW_WORD, REG_FRAME_LEN, 0,          1'b0, 0,  -1},
		'{ROW_WORD, REG_FRAME_LEN, 40960,      1'b0, 1,  0},
		'{ROW_WORD, REG_FRAME_LEN, 57280,      1'b0, 0,  -1},
		'{ROW_WORD, REG_FRAME_LEN, 163840,     1'b0, 3,  0},
		'{ROW_WORD, REG_FRAME_LEN, TC_MAX,     1'b0, 31, 1},
		'{ROW_WORD, REG_FRAME_LEN, TC_MAX,     1'b1, 33, 1},
		'{ROW_WORD, REG_FRAME_LEN, 0,          1'b1, 2,  0},
		'{ROW_WORD, REG_FRAME_LEN, 100000,     1'b0, 2,  0},
		'{ROW_WORD, REG_FRAME_LEN, 40960,      1'b1, 2,  0},
		'{ROW_REG,  REG_REBASE,    1,          1'b0, -1, -1},
		'{ROW_WORD, REG_FRAME_LEN, 500000,     1'b0, 0,  -1},
		'{ROW_WORD, REG_FRAME_LEN, 100,        1'b0, 0,  -1},
		'{ROW_WORD, REG_FRAME_LEN, 581920,     1'b1, 5,  0},
		'{ROW_REG,  REG_FRAME_LEN, 0,          1'b0, -1, -1},
		'{ROW_REG,  REG_THR_FIRST, 1023,       1'b0, -1, -1},
		'{ROW_REG,  REG_THR_MORE,  1023,       1'b0, -1, -1},
		'{ROW_REG,  REG_EXTEND,    0,          1'b0, -1, -1},
		'{ROW_REG,  REG_REBASE,    0,          1'b0, -1, -1},
		'{ROW_WORD, REG_FRAME_LEN, 3,          1'b0, -1, -1},
		'{ROW_WORD, REG_FRAME_LEN, 10,         1'b1, -1, -1},
		'{ROW_REG,  REG_THR_FIRST, 0,          1'b0, -1, -1},
		'{ROW_REG,  REG_THR_MORE,  0,          1'b0, -1, -1},
		'{ROW_REG,  REG_FRAME_LEN, 24'hFFFFFF, 1'b0, -1, -1},
		'{ROW_REG,  REG_EXTEND,    1,          1'b0, -1, -1},
		'{ROW_WORD, REG_FRAME_LEN, 0,          1'b0, 0,  -1},
		'{ROW_WORD, REG_FRAME_LEN, 1,          1'b0, 1,  0},
		'{ROW_WORD, REG_FRAME_LEN, TC_MAX,     1'b1, -1, -1}
	};

	vfr_timecode_to_cfr_remap u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.timecode     (timecode),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.blank        (blank),
		.source_frame (source_frame),
		.output_frame (output_frame),
		.is_last      (is_last),
		.dup_count    (dup_count),
		.drop_count   (drop_count),
		.error_sum    (error_sum),
		.item_count   (item_count),
		.overflow     (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a time sum to the 48-bit range.
	function automatic longint sat48(longint x);
		return (x > TIME_MAX) ? TIME_MAX : x;
	endfunction

	// One output frame entry; advances the output index and the output clock.
	function automatic cfr_word_t emit_copy(logic blank_f, logic [OIDX_W-1:0] src, longint fl);
		cfr_word_t w;
		w = '0;
		w.blank = blank_f;
		w.source_frame = blank_f ? '0 : src;
		w.output_frame = out_count;
		if (out_count != '1)
			out_count++;
		next_out_time = sat48(next_out_time + fl);
		return w;
	endfunction

	// Works out the result words that one timecode word causes and queues them.
	function automatic int remap_timecode(longint tc_in, logic eos);
		cfr_word_t         words[$];
		cfr_word_t         w;
		longint            t, fl, diff, err, lim_first, lim_more, copies, d, s;
		logic              has_prev;
		logic [OIDX_W-1:0] cur;
		int                run, k, n;
		fl = (cf_frame_len == 0) ? 1 : longint'(cf_frame_len);
		cur = in_count;
		has_prev = (in_count != 0);
		lim_first = longint'(cf_thr_first) * fl;
		lim_more = longint'(cf_thr_more) * fl;
		run = 0;
		if (!has_prev)
			first_tc = tc_in;
		t = tc_in;
		if (cf_rebase)
			t = (tc_in >= first_tc) ? tc_in - first_tc : 0;

		// First copy of the source frame, or a drop.
		diff = t - next_out_time;
		if (has_prev) begin
			if (diff * 256 > lim_first) begin
				words = {words, emit_copy(1'b0, cur - 1'b1, fl)};
				diff -= fl;
				run = 1;
			end else if (drop_total != '1) begin
				drop_total++;
			end
		end

		// Further copies, blank ones on the first word of a stream.
		while (diff * 256 > lim_more) begin
			if (run >= RUN_LIMIT) begin
				run_cut = 1'b1;
				break;
			end
			words = {words, emit_copy(!has_prev, cur - 1'b1, fl)};
			diff -= fl;
			run++;
			if (has_prev && dup_total != '1)
				dup_total++;
		end

		err = t - next_out_time;
		if (err < 0)
			err = -err;
		err_total = sat48(err_total + err);
		if (in_count != '1)
			in_count++;

		// Last frame extension by its rounded duration.
		if (eos && cf_extend) begin
			copies = 1;
			if (has_prev && t >= prev_tc) begin
				d = t - prev_tc;
				copies = (2 * d + fl) / (2 * fl);
				if (copies < 1)
					copies = 1;
			end
			if (copies > RUN_LIMIT) begin
				copies = RUN_LIMIT;
				run_cut = 1'b1;
			end
			for (k = 0; k < copies; k++)
				words = {words, emit_copy(1'b0, cur, fl)};
			s = longint'(dup_total) + copies - 1;
			dup_total = (s > INDEX_MAX) ? '1 : s[OIDX_W-1:0];
		end
		prev_tc = t;

		if (eos) begin
			w = '0;
			w.kind = 1'b1;
			w.output_frame = out_count;
			words = {words, w};
		end

		// Statistics as they stand after the whole word.
		n = words.size();
		foreach (words[i]) begin
			words[i].is_last = (i == n - 1);
			words[i].dup_count = dup_total;
			words[i].drop_count = drop_total;
			words[i].error_sum = err_total[TIME_W-1:0];
			words[i].item_count = in_count;
			words[i].overflow = run_cut;
			cfr_frames_due = {cfr_frames_due, words[i]};
		end

		// End of stream returns the stream state to its reset values.
		if (eos) begin
			next_out_time = 0;
			out_count = '0;
			in_count = '0;
			prev_tc = 0;
			first_tc = 0;
			dup_total = '0;
			drop_total = '0;
			err_total = 0;
			run_cut = 1'b0;
		end
		return n;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	// Offers one timecode word, predicts its results on acceptance, then at random idles a while.
	task automatic send_word(input longint tc, input logic eos, output int n_out,
			output logic ovf_out);
		int unsigned r, gap;
		in_valid <= 1'b1;
		timecode <= tc[TC_W-1:0];
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		n_out = remap_timecode(tc, eos);
		ovf_out = (n_out > 0) ? cfr_frames_due[$].overflow : 1'b0;
		r = $urandom_range(0, 99);
		gap = calm ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected word is in, then waits out the settle period.
	task automatic settle();
		in_valid <= 1'b0;
		while (cfr_frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FRAME_LEN: cf_frame_len = val[FL_W-1:0];
			REG_THR_FIRST: cf_thr_first = val[THR_W-1:0];
			REG_THR_MORE:  cf_thr_more = val[THR_W-1:0];
			REG_EXTEND:    cf_extend = val[0];
			REG_REBASE:    cf_rebase = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [FL_W-1:0] fl, logic [THR_W-1:0] tf, logic [THR_W-1:0] tm,
			logic ext, logic reb);
		write_reg(REG_FRAME_LEN, fl);
		write_reg(REG_THR_FIRST, CFG_DATA_W'(tf));
		write_reg(REG_THR_MORE, CFG_DATA_W'(tm));
		write_reg(REG_EXTEND, CFG_DATA_W'(ext));
		write_reg(REG_REBASE, CFG_DATA_W'(reb));
	endtask

	// Receiver pacing: random stalls, one long hold-off on request, none while calm.
	initial begin : rx_pacing
		int unsigned r, span;
		logic        v;
		forever begin
			if (hold_req && !hold_done) begin
				v = 1'b1;
				span = LONG_HOLD;
				hold_done = 1'b1;
			end else if (calm) begin
				v = 1'b0;
				span = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					v = 1'b0;
					span = $urandom_range(1, 4);
				end else if (r < 92) begin
					v = 1'b1;
					span = $urandom_range(1, 3);
				end else begin
					v = 1'b1;
					span = $urandom_range(10, 40);
				end
			end
			out_stall <= v;
			repeat (span) @(posedge clk);
		end
	end

	// Compare each accepted result word with the oldest expected one.
	always @(posedge clk) begin : check_words
		cfr_word_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, blank, source_frame, output_frame, is_last, dup_count, drop_count,
				error_sum, item_count, overflow};
			if (cfr_frames_due.size() == 0) begin
				report_mismatch("result word with nothing expected", 64'(got.output_frame),
					64'(0));
			end else begin
				want = cfr_frames_due.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", 64'(got.kind), 64'(want.kind));
				if (got.blank !== want.blank)
					report_mismatch("blank", 64'(got.blank), 64'(want.blank));
				if (got.source_frame !== want.source_frame)
					report_mismatch("source_frame", 64'(got.source_frame),
						64'(want.source_frame));
				if (got.output_frame !== want.output_frame)
					report_mismatch("output_frame", 64'(got.output_frame),
						64'(want.output_frame));
				if (got.is_last !== want.is_last)
					report_mismatch("is_last", 64'(got.is_last), 64'(want.is_last));
				if (got.dup_count !== want.dup_count)
					report_mismatch("dup_count", 64'(got.dup_count), 64'(want.dup_count));
				if (got.drop_count !== want.drop_count)
					report_mismatch("drop_count", 64'(got.drop_count), 64'(want.drop_count));
				if (got.error_sum !== want.error_sum)
					report_mismatch("error_sum", 64'(got.error_sum), 64'(want.error_sum));
				if (got.item_count !== want.item_count)
					report_mismatch("item_count", 64'(got.item_count), 64'(want.item_count));
				if (got.overflow !== want.overflow)
					report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL vfr_timecode_to_cfr_remap");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t        row;
		int               p, j, len, sent, n_words, r, k;
		logic             ovf;
		longint           tc, nt, fl_eff;
		logic [FL_W-1:0]  fl;
		logic [THR_W-1:0] tf, tm;
		logic             ext, reb;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: reset settings, extremes, drops, blanks, rebasing, zero frame length.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.op == ROW_REG) begin
				settle();
				write_reg(row.reg_idx, row.value[CFG_DATA_W-1:0]);
			end else begin
				send_word(row.value, row.eos, n_words, ovf);
				if (row.exp_n >= 0 && n_words != row.exp_n)
					report_mismatch($sformatf("word count, directed row %0d", i),
						64'(n_words), 64'(row.exp_n));
				if (row.exp_ovf >= 0 && n_words > 0 && ovf != row.exp_ovf[0])
					report_mismatch($sformatf("overflow, directed row %0d", i), 64'(ovf),
						64'(row.exp_ovf));
			end
		end
		settle();
		write_reg(REG_UNUSED, 24'hFFFFFF);

		// Random part: several register settings, mostly well-formed streams.
		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin fl = RST_FRAME_LEN; tf = RST_THR_FIRST; tm = RST_THR_MORE;
					ext = 1'b1; reb = 1'b0; end
				1: begin fl = 1; tf = 1023; tm = 1023; ext = 1'b0; reb = 1'b1; end
				2: begin fl = 24'hFFFFFF; tf = 0; tm = 0; ext = 1'b1; reb = 1'b1; end
				3: begin fl = FL_W'($urandom_range(1, 200000));
					tf = THR_W'($urandom_range(0, 1023));
					tm = THR_W'($urandom_range(0, 1023)); ext = 1'($urandom_range(0, 1));
					reb = 1'($urandom_range(0, 1)); end
				4: begin fl = FL_W'($urandom_range(1, 24'hFFFFFF));
					tf = THR_W'($urandom_range(0, 1023));
					tm = THR_W'($urandom_range(0, 1023)); ext = 1'($urandom_range(0, 1));
					reb = 1'($urandom_range(0, 1)); end
				default: begin fl = 1; tf = THR_W'($urandom_range(0, 1023));
					tm = THR_W'($urandom_range(0, 1023)); ext = 1'b1; reb = 1'b0; end
			endcase
			settle();
			configure(fl, tf, tm, ext, reb);
			calm = (p == 3);
			fl_eff = (fl == 0) ? 1 : longint'(fl);

			if (p == 5) begin
				// Timecodes near the top of the range with the shortest frame.
				for (j = 0; j < 24; j++) begin
					tc = TC_MAX - longint'($urandom_range(0, 65535));
					send_word(tc, j == 23, n_words, ovf);
				end
			end else begin
				sent = 0;
				tc = 0;
				while (sent < 28) begin
					len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
					for (j = 0; j < len; j++) begin
						r = $urandom_range(0, 99);
						if (j == 0 && r < 15)
							nt = longint'({$urandom, $urandom}) & TC_MAX;
						else if (j == 0)
							nt = longint'($urandom_range(0, 3)) * fl_eff
								+ longint'($urandom_range(0, 32'(fl_eff)));
						else if (r < 8)
							nt = longint'({$urandom, $urandom}) & TC_MAX;
						else if (r < 14)
							nt = tc - longint'($urandom_range(0, 3)) * fl_eff
								- longint'($urandom_range(0, 32'(fl_eff)));
						else begin
							k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
							nt = tc + longint'(k) * fl_eff
								+ longint'($urandom_range(0, 32'(fl_eff))) - fl_eff / 2;
						end
						tc = (nt < 0) ? 0 : (nt > TC_MAX) ? TC_MAX : nt;
						if (p == 0 && sent == 12)
							hold_req = 1'b1;
						send_word(tc, (j == len - 1) && ($urandom_range(0, 9) != 0),
							n_words, ovf);
						sent++;
					end
				end
			end
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0)
			$display("PASS vfr_timecode_to_cfr_remap");
		else
			$display("FAIL vfr_timecode_to_cfr_remap");
		$finish;
	end

endmodule
